[hw/rtl/pfc_pkg.sv]
// Shared constants and helper functions for the Playfair digraph cipher.
package pfc_pkg;
   localparam logic [1:0] TYPE_KEY   = 2'd0;
   localparam logic [1:0] TYPE_START = 2'd1;
   localparam logic [1:0] TYPE_TEXT  = 2'd2;
   localparam logic [1:0] TYPE_END   = 2'd3;

   localparam logic [5:0] NO_LETTER    = 6'd63;
   localparam logic [5:0] HELD_NO_PRED = 6'd62;
   localparam logic [4:0] LETTER_I     = 5'd8;
   localparam logic [4:0] LETTER_J     = 5'd9;
   localparam logic [4:0] LETTER_X     = 5'd23;
   localparam logic [4:0] SQUARE_CELLS = 5'd25;
   localparam logic [4:0] LETTER_LAST  = 5'd25;
   localparam logic [6:0] ASCII_A      = 7'd65;

   // filtered letter (0..25) or NO_LETTER
   function automatic logic [5:0] to_letter(input logic [7:0] b);
      logic [7:0] v;
      v = 8'd0;
      if (b >= 8'd97 && b <= 8'd122) v = b - 8'd97;
      else if (b >= 8'd65 && b <= 8'd90) v = b - 8'd65;
      else return NO_LETTER;
      if (v[4:0] == LETTER_J) v = {3'd0, LETTER_I};
      return v[5:0];
   endfunction

   // cell index -> row and column
   function automatic logic [2:0] cell_row(input logic [4:0] p);
      return (p >= 5'd20) ? 3'd4 : (p >= 5'd15) ? 3'd3 : (p >= 5'd10) ? 3'd2 :
             (p >= 5'd5) ? 3'd1 : 3'd0;
   endfunction

   function automatic logic [2:0] cell_col(input logic [4:0] p);
      logic [4:0] r5;
      r5 = 5'(cell_row(p)) * 5'd5;
      return 3'(p - r5);
   endfunction

   function automatic logic [2:0] add_mod5(input logic [2:0] a, input logic [2:0] s);
      logic [3:0] t;
      t = 4'(a) + 4'(s);
      return (t >= 4'd5) ? 3'(t - 4'd5) : t[2:0];
   endfunction

   function automatic logic [4:0] cell_of(input logic [2:0] r, input logic [2:0] c);
      return 5'(5'(r) * 5'd5 + 5'(c));
   endfunction
endpackage

[hw/rtl/playfair_digraph_cipher.sv]
// Top level of the streaming Playfair digraph cipher.
//
//  channel | dir | payload
//  req_    | in  | tdata[7:0] data_byte, tuser[1:0] req_type
//  rsp_    | out | tdata[6:0] out_char, tlast last
//  csr_    | cfg | addr 0: encrypt_mode (bit 0, reset 1)
//
// Keyword byte: ST_KEY checks the used flag and writes together. Start item: a walk over
// the 26 letters filling the unused cells. Non-letter text or an end with nothing pending
// leaves the engine idle; text that only opens a pair passes ST_FEED. A completed pair
// runs ST_FEED, ST_P1, ST_P2, ST_S1, ST_S2 and ST_EMIT; a doubled letter feeds an X first.
// Reset is synchronous; items are taken only while the result queue is empty.
module playfair_digraph_cipher import pfc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [6:0]  rsp_tdata,   // [6:0] out_char
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [0:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_KEY   = 4'd1;
   localparam logic [3:0] ST_FILL  = 4'd2;
   localparam logic [3:0] ST_FEED  = 4'd3;
   localparam logic [3:0] ST_P1    = 4'd4;
   localparam logic [3:0] ST_P2    = 4'd5;
   localparam logic [3:0] ST_S1    = 4'd6;
   localparam logic [3:0] ST_S2    = 4'd7;
   localparam logic [3:0] ST_EMIT  = 4'd8;

   // memories: square cell -> letter, letter -> cell
   logic [4:0] square_mem [25];
   logic [4:0] place_mem  [26];
   logic [4:0] square_rd_ff, place_rd_ff;
   logic [4:0] sq_raddr, pl_raddr;
   logic       sq_we, pl_we;

   logic [25:0] used_ff;
   logic [4:0]  fill_ff;
   logic [5:0]  prev_ff, pair_ff, held_ff, hprev_ff;
   logic        enc_ff;
   logic [3:0]  state_ff, state_in;
   logic [5:0]  letter_ff;    // letter being fed
   logic        xfirst_ff;    // an X is fed before letter_ff
   logic        end_ff;
   logic [4:0]  walk_ff, p1_ff, p2_ff, o1_ff;
   logic [4:0]  feed_b;
   logic [4:0]  p2_cur;

   logic        fifo_push;
   logic [7:0]  fifo_data;
   logic [2:0]  free_count;
   logic [7:0]  rsp_word;

   assign csr_pready = 1'b1;
   assign csr_prdata = {31'd0, enc_ff};
   assign req_tready = (state_ff == ST_IDLE) && (free_count == 3'd4);

   pfc_out_fifo u_fifo (
      .clock(clock), .reset(reset), .push(fifo_push), .push_data(fifo_data),
      .free_count(free_count), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_word)
   );
   assign rsp_tdata = rsp_word[6:0];
   assign rsp_tlast = rsp_word[7];

   // in ST_P2 the second place is still on the read port
   assign p2_cur = (state_ff == ST_P2) ? place_rd_ff : p2_ff;

   // pair geometry
   logic [2:0] r1, c1, r2, c2, sh;
   logic [4:0] q1, q2;
   always_comb begin
      r1 = cell_row(p1_ff); c1 = cell_col(p1_ff);
      r2 = cell_row(p2_cur); c2 = cell_col(p2_cur);
      sh = enc_ff ? 3'd1 : 3'd4;
      if (r1 == r2) begin
         q1 = cell_of(r1, add_mod5(c1, sh));
         q2 = cell_of(r2, add_mod5(c2, sh));
      end else if (c1 == c2) begin
         q1 = cell_of(add_mod5(r1, sh), c1);
         q2 = cell_of(add_mod5(r2, sh), c2);
      end else begin
         q1 = cell_of(r1, c2);
         q2 = cell_of(r2, c1);
      end
   end

   // decrypt X removal on the two deciphered letters; pushes up to 4 letters
   logic [4:0] dec_out [4];
   logic [2:0] dec_n;
   logic [5:0] held_a, hprev_a;
   always_comb begin
      logic [4:0] d;
      dec_n = 3'd0;
      held_a = held_ff;
      hprev_a = hprev_ff;
      for (int k = 0; k < 4; k++) dec_out[k] = LETTER_X;
      for (int j = 0; j < 2; j++) begin
         d = (j == 0) ? o1_ff : square_rd_ff;
         if (held_a != NO_LETTER) begin
            if (!(held_a < 6'd26 && held_a[4:0] == d)) begin
               dec_out[dec_n[1:0]] = LETTER_X;
               dec_n = dec_n + 3'd1;
            end
            held_a = NO_LETTER;
         end
         if (d == LETTER_X) held_a = (hprev_a < 6'd26) ? hprev_a : HELD_NO_PRED;
         else begin
            dec_out[dec_n[1:0]] = d;
            dec_n = dec_n + 3'd1;
         end
         hprev_a = {1'b0, d};
      end
   end

   // emit sequencing: ST_EMIT pushes one letter per cycle
   logic [2:0] emit_idx_ff, emit_cnt_ff;
   logic [4:0] emit_buf_ff [4];

   assign feed_b = xfirst_ff ? LETTER_X : letter_ff[4:0];

   always_comb begin
      state_in = state_ff;
      sq_raddr = '0;
      pl_raddr = '0;
      sq_we = 1'b0;
      pl_we = 1'b0;
      fifo_push = 1'b0;
      fifo_data = {1'b0, ASCII_A + 7'(emit_buf_ff[emit_idx_ff[1:0]])};
      unique case (state_ff)
         ST_IDLE: ;
         ST_KEY: if (letter_ff != NO_LETTER && !used_ff[letter_ff[4:0]] &&
                     fill_ff < SQUARE_CELLS) begin
            sq_we = 1'b1; pl_we = 1'b1;
         end
         ST_FILL: if (walk_ff != LETTER_J && !used_ff[walk_ff] && fill_ff < SQUARE_CELLS) begin
            sq_we = 1'b1; pl_we = 1'b1;
         end
         ST_FEED: pl_raddr = pair_ff[4:0];
         ST_P1: pl_raddr = feed_b;
         ST_P2: sq_raddr = q1;
         ST_S1: sq_raddr = q2;
         ST_S2: ;
         ST_EMIT: fifo_push = emit_idx_ff < emit_cnt_ff;
         default: ;
      endcase
      if (fifo_push && end_ff && emit_idx_ff + 3'd1 == emit_cnt_ff && !xfirst_ff)
         fifo_data[7] = 1'b1;
   end

   logic [4:0] wr_letter;
   assign wr_letter = (state_ff == ST_KEY) ? letter_ff[4:0] : walk_ff;

   always_ff @(posedge clock) begin
      if (sq_we) square_mem[fill_ff] <= wr_letter;
      if (pl_we) place_mem[wr_letter] <= fill_ff;
      square_rd_ff <= square_mem[sq_raddr];
      place_rd_ff  <= place_mem[pl_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         used_ff <= '0;
         fill_ff <= '0;
         prev_ff <= NO_LETTER;
         pair_ff <= NO_LETTER;
         held_ff <= NO_LETTER;
         hprev_ff <= NO_LETTER;
         enc_ff <= 1'b1;
         emit_idx_ff <= '0;
         emit_cnt_ff <= '0;
         end_ff <= 1'b0;
         xfirst_ff <= 1'b0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == 1'b0)
            enc_ff <= csr_pwdata[0];
         unique case (state_ff)
            ST_IDLE: if (req_tvalid && req_tready) begin
               letter_ff <= (req_tuser == TYPE_END) ? {1'b0, LETTER_X} : to_letter(req_tdata);
               end_ff <= req_tuser == TYPE_END;
               xfirst_ff <= req_tuser == TYPE_TEXT && to_letter(req_tdata) != NO_LETTER &&
                            prev_ff == to_letter(req_tdata);
               walk_ff <= '0;
               unique case (req_tuser)
                  TYPE_KEY: state_ff <= ST_KEY;
                  TYPE_START: state_ff <= ST_FILL;
                  TYPE_TEXT: begin
                     if (to_letter(req_tdata) != NO_LETTER) begin
                        prev_ff <= to_letter(req_tdata);
                        state_ff <= ST_FEED;
                     end
                  end
                  TYPE_END: begin
                     if (pair_ff != NO_LETTER) state_ff <= ST_FEED;
                     else begin
                        prev_ff <= NO_LETTER;
                        held_ff <= NO_LETTER;
                        hprev_ff <= NO_LETTER;
                     end
                  end
                  default: ;
               endcase
            end
            ST_KEY: begin
               if (sq_we) begin
                  used_ff[letter_ff[4:0]] <= 1'b1;
                  fill_ff <= fill_ff + 5'd1;
               end
               state_ff <= ST_IDLE;
            end
            ST_FILL: begin
               if (sq_we) begin
                  used_ff[walk_ff] <= 1'b1;
                  fill_ff <= fill_ff + 5'd1;
               end
               if (walk_ff == LETTER_LAST) begin
                  prev_ff <= NO_LETTER;
                  pair_ff <= NO_LETTER;
                  held_ff <= NO_LETTER;
                  hprev_ff <= NO_LETTER;
                  state_ff <= ST_IDLE;
               end else walk_ff <= walk_ff + 5'd1;
            end
            ST_FEED: begin
               if (pair_ff == NO_LETTER) begin
                  // store first of pair
                  pair_ff <= {1'b0, feed_b};
                  if (xfirst_ff) begin
                     xfirst_ff <= 1'b0;
                     state_ff <= ST_FEED;
                  end else state_ff <= ST_IDLE;
               end else state_ff <= ST_P1;
            end
            ST_P1: begin
               p1_ff <= 5'(place_rd_ff);
               state_ff <= ST_P2;
            end
            ST_P2: begin
               p2_ff <= place_rd_ff;
               state_ff <= ST_S1;
            end
            ST_S1: begin
               o1_ff <= square_rd_ff;
               state_ff <= ST_S2;
            end
            ST_S2: begin
               pair_ff <= NO_LETTER;
               emit_idx_ff <= '0;
               if (enc_ff) begin
                  emit_buf_ff[0] <= o1_ff;
                  emit_buf_ff[1] <= square_rd_ff;
                  emit_cnt_ff <= 3'd2;
               end else begin
                  for (int k = 0; k < 4; k++) emit_buf_ff[k] <= dec_out[k];
                  emit_cnt_ff <= dec_n;
                  held_ff <= held_a;
                  hprev_ff <= hprev_a;
               end
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (emit_idx_ff < emit_cnt_ff) emit_idx_ff <= emit_idx_ff + 3'd1;
               else if (xfirst_ff) begin
                  xfirst_ff <= 1'b0;
                  state_ff <= ST_FEED;
               end else begin
                  if (end_ff) begin
                     prev_ff <= NO_LETTER;
                     held_ff <= NO_LETTER;
                     hprev_ff <= NO_LETTER;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

[hw/rtl/pfc_out_fifo.sv]
// Small result queue parting the engine from the result channel.
module pfc_out_fifo import pfc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  logic [7:0] push_data,
   output logic [2:0] free_count,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata
);
   logic [7:0] entry_ff [4];
   logic [1:0] wr_ptr_ff, rd_ptr_ff;
   logic [2:0] count_ff;
   logic       pop;

   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = count_ff != 3'd0;
   assign rsp_tdata  = entry_ff[rd_ptr_ff];
   assign free_count = 3'd4 - count_ff;

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 2'd1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 2'd1;
         count_ff <= count_ff + 3'(push) - 3'(pop);
      end
   end
endmodule

[dv/pfc_checker.sv]
// Item checker for the Playfair cipher: predicts letters from accepted items and compares them.
module pfc_checker import pfc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [6:0]  rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [0:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          pending,
   output int          errors
);
   typedef struct packed {
      logic [6:0] ch;
      logic       last;
   } letter_type;

   letter_type cipher_q[$];
   logic [4:0] square[25];
   logic [4:0] place[26];
   logic       used[26];
   int         fill;
   logic [5:0] prev_letter;
   logic [5:0] pair_first;
   logic [11:0] held;
   logic       encrypt;
   int         nres;

   assign pending = cipher_q.size();

   task automatic report(input string msg);
      $display("checker: mismatch: %s", msg);
      errors++;
   endtask

   function automatic logic [5:0] filter_byte(input logic [7:0] b);
      logic [5:0] v;
      if (b >= 8'd97 && b <= 8'd122) v = 6'(b - 8'd97);
      else if (b >= 8'd65 && b <= 8'd90) v = 6'(b - 8'd65);
      else return NO_LETTER;
      if (v == 6'(LETTER_J)) v = 6'(LETTER_I);
      return v;
   endfunction

   task automatic clear_pairing();
      prev_letter = NO_LETTER;
      pair_first  = NO_LETTER;
      held        = 12'hFFF;
   endtask

   task automatic place_letter(input logic [5:0] v);
      if (v >= 26 || used[v] || fill >= 25) return;
      used[v] = 1'b1;
      square[fill] = v[4:0];
      place[v] = 5'(fill);
      fill++;
   endtask

   task automatic emit(input logic [4:0] v);
      letter_type t;
      if (nres >= 4) return;
      t.ch = 7'(ASCII_A + 7'(v));
      t.last = 1'b0;
      cipher_q = {cipher_q, t};
      nres++;
   endtask

   // decrypt side: drop an X between equal letters and a trailing X
   task automatic push_plain(input logic [4:0] d);
      logic [5:0] pv, hx;
      pv = held[5:0];
      hx = held[11:6];
      if (hx != NO_LETTER) begin
         if (!(hx < 26 && hx == 6'(d))) emit(LETTER_X);
         hx = NO_LETTER;
      end
      if (d == LETTER_X) hx = (pv < 26) ? pv : HELD_NO_PRED;
      else emit(d);
      pv = 6'(d);
      held = {hx, pv};
   endtask

   task automatic cipher_pair(input logic [5:0] a, input logic [5:0] b);
      int p1, p2, r1, c1, r2, c2, sh;
      logic [4:0] o1, o2;
      p1 = place[a] % 25;
      p2 = place[b] % 25;
      r1 = p1 / 5; c1 = p1 % 5; r2 = p2 / 5; c2 = p2 % 5;
      sh = encrypt ? 1 : 4;
      if (r1 == r2) begin
         o1 = square[r1 * 5 + (c1 + sh) % 5];
         o2 = square[r2 * 5 + (c2 + sh) % 5];
      end else if (c1 == c2) begin
         o1 = square[((r1 + sh) % 5) * 5 + c1];
         o2 = square[((r2 + sh) % 5) * 5 + c2];
      end else begin
         o1 = square[r1 * 5 + c2];
         o2 = square[r2 * 5 + c1];
      end
      if (encrypt) begin
         emit(o1);
         emit(o2);
      end else begin
         push_plain(o1);
         push_plain(o2);
      end
   endtask

   task automatic feed(input logic [5:0] v);
      if (pair_first == NO_LETTER) begin
         pair_first = v;
      end else begin
         cipher_pair(pair_first, v);
         pair_first = NO_LETTER;
      end
   endtask

   task automatic predict_item(input logic [1:0] kind, input logic [7:0] b);
      logic [5:0] v;
      nres = 0;
      case (kind)
         TYPE_KEY: place_letter(filter_byte(b));
         TYPE_START: begin
            for (int i = 0; i < 26; i++)
               if (i != LETTER_J) place_letter(6'(i));
            clear_pairing();
         end
         TYPE_TEXT: begin
            v = filter_byte(b);
            if (v != NO_LETTER) begin
               if (prev_letter == v) feed(6'(LETTER_X));
               feed(v);
               prev_letter = v;
            end
         end
         default: begin
            if (pair_first != NO_LETTER) feed(6'(LETTER_X));
            clear_pairing();
            if (nres > 0) cipher_q[$].last = 1'b1;
         end
      endcase
   endtask

   initial errors = 0;

   always @(posedge clock) begin
      letter_type want;
      if (reset) begin
         cipher_q.delete();
         for (int i = 0; i < 25; i++) square[i] = '0;
         for (int i = 0; i < 26; i++) begin
            place[i] = '0;
            used[i] = 1'b0;
         end
         fill = 0;
         encrypt = 1'b1;
         clear_pairing();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == 1'b0)
            encrypt = csr_pwdata[0];
         if (req_tvalid && req_tready) predict_item(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (cipher_q.size() == 0) begin
               report($sformatf("unexpected letter %h last %b", rsp_tdata, rsp_tlast));
            end else begin
               want = cipher_q.pop_front();
               if (rsp_tdata !== want.ch)
                  report($sformatf("out_char %h, want %h", rsp_tdata, want.ch));
               if (rsp_tlast !== want.last)
                  report($sformatf("last %b, want %b", rsp_tlast, want.last));
            end
         end
      end
   end
endmodule

[dv/testbench.sv]
// Top of the Playfair cipher testbench: stimulus, handshake idling and verdict.
module testbench;
   import pfc_pkg::*;

   localparam int STALL_LIMIT = 5000;

   logic        clock, reset;
   logic        req_tvalid, req_tready;
   logic [7:0]  req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid, rsp_tready;
   logic [6:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel, csr_penable, csr_pwrite;
   logic [0:0]  csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic        csr_pready;
   int          pending, errors;
   int          stall_cycles;
   bit          no_idle;
   logic [7:0]  last_text;

   playfair_digraph_cipher i_dut (.*);

   pfc_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      reset = 1'b1; req_tvalid = 1'b0; req_tdata = '0; req_tuser = TYPE_KEY;
      rsp_tready = 1'b0; csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0; no_idle = 1'b0; last_text = "A";
   end

   always @(posedge clock)
      rsp_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 21);

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send(input logic [1:0] kind, input logic [7:0] b);
      if (!no_idle && $urandom_range(99) < 21) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 40);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_str(input logic [1:0] kind, input string s);
      for (int i = 0; i < s.len(); i++) send(kind, s[i]);
   endtask

   // also lets a result-free item finish before a register write
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_mode(input logic m);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= '0; csr_pwdata <= {$urandom} & ~32'd1 | 32'(m);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [7:0] text_byte();
      int r;
      r = $urandom_range(99);
      if (r < 15) return last_text;
      if (r < 80) return 8'($urandom_range(25)) + ($urandom_range(1) ? 8'd65 : 8'd97);
      return 8'($urandom_range(255));
   endfunction

   task automatic random_phase(input int items);
      int sent, len;
      sent = 0;
      while (sent < items) begin
         if ($urandom_range(2) == 0) begin
            send(TYPE_START, 8'($urandom));
            sent++;
         end
         if ($urandom_range(9) == 0) begin
            send(TYPE_KEY, 8'($urandom));
            sent++;
         end
         len = $urandom_range(12, 1);
         for (int i = 0; i < len; i++) begin
            last_text = text_byte();
            send(TYPE_TEXT, last_text);
         end
         sent += len;
         send(TYPE_END, 8'($urandom));
         sent++;
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_mode(1'b1);
      send_str(TYPE_KEY, "Playjf 9Z");
      send(TYPE_KEY, 8'hFF);
      send(TYPE_KEY, 8'h80);
      send(TYPE_KEY, 8'h00);
      send(TYPE_START, 8'h00);
      send(TYPE_KEY, "q");         // dropped: square is already full
      send_str(TYPE_TEXT, "aZjI~ee");
      send(TYPE_END, 8'hFF);
      send(TYPE_END, 8'h00);       // second end emits nothing
      send_str(TYPE_TEXT, "XX");   // text after end with no start
      send(TYPE_END, 8'h00);
      send(TYPE_START, 8'h00);
      drain();
      random_phase(60);
      drain();
      write_mode(1'b0);
      no_idle = 1'b1;
      send_str(TYPE_TEXT, "BXBX");
      send(TYPE_END, 8'h00);
      random_phase(60);
      no_idle = 1'b0;
      drain();
      write_mode(1'b1);
      random_phase(55);
      drain();
      write_mode(1'b0);
      random_phase(55);
      drain();
      if (errors == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end
endmodule
